// File: design/pwc_pkg.sv
`default_nettype none
package pwc_pkg;
   localparam int MaxWidthDefault    = 320;
   localparam int MaxHeightDefault   = 240;
   localparam int FractionBitsDefault = 8;

   localparam int CfgAddrBits = 4;
   localparam logic [CfgAddrBits-1:0] AddrThreshold = 4'h0;
   localparam logic [CfgAddrBits-1:0] AddrWidth     = 4'h4;
   localparam logic [CfgAddrBits-1:0] AddrHeight    = 4'h8;
   localparam logic [CfgAddrBits-1:0] AddrRadius    = 4'hC;

   localparam logic [7:0]  ThresholdReset = 8'd128;
   localparam logic [8:0]  WidthReset     = 9'd320;
   localparam logic [7:0]  HeightReset    = 8'd240;
   localparam logic [15:0] RadiusReset    = 16'd144;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_SCAN,
      ST_DRAIN,
      ST_DIVIDE,
      ST_OUT
   } state_type;
endpackage
`default_nettype wire

// File: design/peak_windowed_centroid.sv
`default_nettype none
// Words load at one word per cycle, accepted only in the load state; after the last one
// the stored frame is rescanned at one pixel per cycle, then two serial divisions and
// the output state follow. A peak at or below threshold skips the rescan and divisions.
// No word of the next frame is taken until the result enters the output word, as the single
// frame memory port and the one-bit-per-cycle divider serve one frame at a time.
// Reset: synchronous; state and configuration registers reset, the frame memory is not cleared.
module peak_windowed_centroid #(
   parameter int MAX_WIDTH     = pwc_pkg::MaxWidthDefault,
   parameter int MAX_HEIGHT    = pwc_pkg::MaxHeightDefault,
   parameter int FRACTION_BITS = pwc_pkg::FractionBitsDefault
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_pixel,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_found,
   output logic [7:0]       rsp_peak_value,
   output logic [16:0]      rsp_centroid_x,
   output logic [15:0]      rsp_centroid_y,
   output logic [16:0]      rsp_cluster_pixels,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [pwc_pkg::CfgAddrBits-1:0] csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   localparam int Depth   = MAX_WIDTH * MAX_HEIGHT;
   localparam int IdxBits = $clog2(Depth + 1);
   localparam int AdrBits = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int ColBits = $clog2(MAX_WIDTH + 1);
   localparam int RowBits = $clog2(MAX_HEIGHT + 1);
   localparam int WtBits  = IdxBits + 8;
   localparam int MomBits = WtBits + ((ColBits > RowBits) ? ColBits : RowBits);
   localparam int NumBits = MomBits + FRACTION_BITS;
   localparam int DBits   = ((ColBits > RowBits) ? ColBits : RowBits) + 1;

   // Configuration registers.
   logic [7:0]  thr_ff;
   logic [8:0]  wcfg_ff;
   logic [7:0]  hcfg_ff;
   logic [15:0] rad_ff;
   logic        cfg_wr;

   assign csr_pready = 1'b1;
   assign cfg_wr = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff  <= pwc_pkg::ThresholdReset;
         wcfg_ff <= pwc_pkg::WidthReset;
         hcfg_ff <= pwc_pkg::HeightReset;
         rad_ff  <= pwc_pkg::RadiusReset;
      end else if (cfg_wr) begin
         case (csr_paddr)
            pwc_pkg::AddrThreshold: thr_ff  <= csr_pwdata[7:0];
            pwc_pkg::AddrWidth:     wcfg_ff <= csr_pwdata[8:0];
            pwc_pkg::AddrHeight:    hcfg_ff <= csr_pwdata[7:0];
            pwc_pkg::AddrRadius:    rad_ff  <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr)
         pwc_pkg::AddrThreshold: csr_prdata = {24'd0, thr_ff};
         pwc_pkg::AddrWidth:     csr_prdata = {23'd0, wcfg_ff};
         pwc_pkg::AddrHeight:    csr_prdata = {24'd0, hcfg_ff};
         pwc_pkg::AddrRadius:    csr_prdata = {16'd0, rad_ff};
         default:                csr_prdata = '0;
      endcase
   end

   // Effective frame size: zero counts as one, large values saturate.
   logic [ColBits-1:0] eff_w;
   logic [RowBits-1:0] eff_h;
   always_comb begin
      if (wcfg_ff == '0) eff_w = ColBits'(1);
      else if (32'(wcfg_ff) > MAX_WIDTH) eff_w = ColBits'(MAX_WIDTH);
      else eff_w = ColBits'(wcfg_ff);
      if (hcfg_ff == '0) eff_h = RowBits'(1);
      else if (32'(hcfg_ff) > MAX_HEIGHT) eff_h = RowBits'(MAX_HEIGHT);
      else eff_h = RowBits'(hcfg_ff);
   end

   // Frame memory.
   logic [7:0] mem [Depth];
   logic [7:0] rd_ff;

   pwc_pkg::state_type state_ff, state_in;

   // Load position tracked as column and row counters.
   logic [IdxBits-1:0] lidx_ff, lidx_in;
   logic [ColBits-1:0] lcol_ff, lcol_in;
   logic [RowBits-1:0] lrow_ff, lrow_in;
   logic [7:0]         best_ff, best_in;
   logic [ColBits-1:0] bcol_ff, bcol_in;
   logic [RowBits-1:0] brow_ff, brow_in;

   // Scan counters and the pipelined pixel position.
   logic [ColBits-1:0] scol_ff, scol_in, pcol_ff;
   logic [RowBits-1:0] srow_ff, srow_in, prow_ff;
   logic [AdrBits-1:0] sadr_ff, sadr_in;
   logic               pv_ff, pv_in;
   logic [ColBits-1:0] fw_ff, fw_in;
   logic [RowBits-1:0] fh_ff, fh_in;

   logic [WtBits-1:0]  wt_ff, wt_in;
   logic [MomBits-1:0] mx_ff, mx_in, my_ff, my_in;
   logic [IdxBits-1:0] cnt_ff, cnt_in;
   logic               dsel_ff, dsel_in;
   logic [NumBits-1:0] qx_ff, qx_in;

   logic               ov_ff, ov_in;
   logic               of_ff, of_in;
   logic [7:0]         opk_ff, opk_in;
   logic [16:0]        ox_ff, ox_in, ocnt_ff, ocnt_in;
   logic [15:0]        oy_ff, oy_in;

   // Output word, held while the receiver stalls.
   logic               rfound_ff;
   logic [7:0]         rpk_ff;
   logic [16:0]        rx_ff, rcnt_ff;
   logic [15:0]        ry_ff;

   logic               div_start, div_busy;
   logic [NumBits-1:0] div_num, div_q;

   pwc_divider #(.NUM_BITS(NumBits), .DEN_BITS(WtBits)) u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .numerator(div_num), .denominator(wt_ff),
      .busy(div_busy), .quotient(div_q)
   );

   logic               req_acc, last_px;
   logic [IdxBits-1:0] total;
   logic signed [DBits-1:0] dx, dy;
   logic signed [2*DBits-1:0] dxw, dyw;
   logic [2*DBits-1:0] dx_sq, dy_sq, dsq;
   logic               incl;

   assign req_acc   = req_valid && !req_stall;
   assign req_stall = (state_ff != pwc_pkg::ST_LOAD);
   assign total     = IdxBits'(eff_w * eff_h);
   assign last_px   = (lidx_ff + 1'b1 >= total);

   always_ff @(posedge clock) begin
      if (req_acc && lidx_ff < IdxBits'(Depth)) begin
         mem[lidx_ff[AdrBits-1:0]] <= req_pixel;
      end
      rd_ff <= mem[sadr_ff];
   end

   // Distance test on the pixel that reads out this cycle.
   always_comb begin
      dx    = $signed({1'b0, pcol_ff}) - $signed({1'b0, bcol_ff});
      dy    = $signed(DBits'(prow_ff)) - $signed(DBits'(brow_ff));
      dxw   = {{DBits{dx[DBits-1]}}, dx};
      dyw   = {{DBits{dy[DBits-1]}}, dy};
      dx_sq = $unsigned(dxw * dxw);
      dy_sq = $unsigned(dyw * dyw);
      dsq   = dx_sq + dy_sq;
      incl  = pv_ff && (rd_ff > thr_ff) && (dsq <= (2*DBits)'(rad_ff));
   end

   always_comb begin
      state_in = state_ff;
      lidx_in = lidx_ff; lcol_in = lcol_ff; lrow_in = lrow_ff;
      best_in = best_ff; bcol_in = bcol_ff; brow_in = brow_ff;
      scol_in = scol_ff; srow_in = srow_ff; sadr_in = sadr_ff; pv_in = 1'b0;
      fw_in = fw_ff; fh_in = fh_ff;
      wt_in = wt_ff; mx_in = mx_ff; my_in = my_ff; cnt_in = cnt_ff;
      dsel_in = dsel_ff; qx_in = qx_ff;
      ov_in = ov_ff; of_in = of_ff; opk_in = opk_ff;
      ox_in = ox_ff; oy_in = oy_ff; ocnt_in = ocnt_ff;
      div_start = 1'b0;
      div_num = dsel_ff ? (NumBits'(my_ff) << FRACTION_BITS)
                        : (NumBits'(mx_ff) << FRACTION_BITS);
      if (ov_ff && !rsp_stall) ov_in = 1'b0;
      case (state_ff)
         pwc_pkg::ST_LOAD: begin
            if (req_acc) begin
               if (req_pixel > best_ff) begin
                  best_in = req_pixel; bcol_in = lcol_ff; brow_in = lrow_ff;
               end
               if (lcol_ff + 1'b1 >= eff_w) begin
                  lcol_in = '0; lrow_in = lrow_ff + 1'b1;
               end else begin
                  lcol_in = lcol_ff + 1'b1;
               end
               lidx_in = lidx_ff + 1'b1;
               if (last_px) begin
                  lidx_in = '0; lcol_in = '0; lrow_in = '0;
                  fw_in = eff_w; fh_in = eff_h;
                  wt_in = '0; mx_in = '0; my_in = '0; cnt_in = '0;
                  scol_in = '0; srow_in = '0; sadr_in = '0;
                  if (req_pixel > best_ff) opk_in = req_pixel;
                  else opk_in = best_ff;
                  if (opk_in > thr_ff) begin
                     state_in = pwc_pkg::ST_SCAN;
                  end else begin
                     of_in = 1'b0; ox_in = '0; oy_in = '0; ocnt_in = '0;
                     best_in = '0; bcol_in = '0; brow_in = '0;
                     state_in = pwc_pkg::ST_OUT;
                  end
               end
            end
         end
         pwc_pkg::ST_SCAN: begin
            // Issue one read per cycle.
            pv_in = 1'b1;
            sadr_in = sadr_ff + 1'b1;
            if (scol_ff + 1'b1 >= fw_ff) begin
               scol_in = '0; srow_in = srow_ff + 1'b1;
               if (srow_ff + 1'b1 >= fh_ff) state_in = pwc_pkg::ST_DRAIN;
            end else begin
               scol_in = scol_ff + 1'b1;
            end
         end
         pwc_pkg::ST_DRAIN: begin
            if (!pv_ff) begin
               if (wt_ff != '0) begin
                  dsel_in = 1'b0; div_start = 1'b1;
                  div_num = NumBits'(mx_ff) << FRACTION_BITS;
                  state_in = pwc_pkg::ST_DIVIDE;
               end else begin
                  of_in = 1'b0; ox_in = '0; oy_in = '0; ocnt_in = '0;
                  state_in = pwc_pkg::ST_OUT;
               end
               best_in = '0; bcol_in = '0; brow_in = '0;
            end
         end
         pwc_pkg::ST_DIVIDE: begin
            if (!div_busy && !div_start) begin
               if (!dsel_ff) begin
                  qx_in = div_q; dsel_in = 1'b1; div_start = 1'b1;
                  div_num = NumBits'(my_ff) << FRACTION_BITS;
               end else begin
                  of_in = 1'b1; ox_in = qx_ff[16:0]; oy_in = div_q[15:0];
                  ocnt_in = 17'(cnt_ff);
                  state_in = pwc_pkg::ST_OUT;
               end
            end
         end
         pwc_pkg::ST_OUT: begin
            if (!ov_ff) begin
               ov_in = 1'b1;
               state_in = pwc_pkg::ST_LOAD;
            end
         end
         default: state_in = pwc_pkg::ST_LOAD;
      endcase
      // Accumulate the pixel returning from memory.
      if (incl) begin
         wt_in  = wt_ff + WtBits'(rd_ff);
         mx_in  = mx_ff + MomBits'(rd_ff * pcol_ff);
         my_in  = my_ff + MomBits'(rd_ff * prow_ff);
         cnt_in = cnt_ff + 1'b1;
      end
   end

   // A start issued this cycle makes the divider busy from the next.
   logic dwait_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pwc_pkg::ST_LOAD;
         lidx_ff <= '0; lcol_ff <= '0; lrow_ff <= '0;
         best_ff <= '0; bcol_ff <= '0; brow_ff <= '0;
         pv_ff <= 1'b0; ov_ff <= 1'b0; dwait_ff <= 1'b0;
      end else begin
         state_ff <= (state_ff == pwc_pkg::ST_DIVIDE && dwait_ff) ? state_ff : state_in;
         lidx_ff <= lidx_in; lcol_ff <= lcol_in; lrow_ff <= lrow_in;
         best_ff <= best_in; bcol_ff <= bcol_in; brow_ff <= brow_in;
         pv_ff <= pv_in; ov_ff <= ov_in; dwait_ff <= div_start;
      end
      scol_ff <= scol_in; srow_ff <= srow_in; sadr_ff <= sadr_in;
      pcol_ff <= scol_ff; prow_ff <= srow_ff;
      fw_ff <= fw_in; fh_ff <= fh_in;
      wt_ff <= wt_in; mx_ff <= mx_in; my_ff <= my_in; cnt_ff <= cnt_in;
      if (!(state_ff == pwc_pkg::ST_DIVIDE && dwait_ff)) begin
         dsel_ff <= dsel_in; qx_ff <= qx_in;
         of_ff <= of_in; ox_ff <= ox_in; oy_ff <= oy_in; ocnt_ff <= ocnt_in;
      end
      opk_ff <= opk_in;
   end

   // The finished result moves to the output word when the channel is free.
   always_ff @(posedge clock) begin
      if (state_ff == pwc_pkg::ST_OUT && !ov_ff) begin
         rfound_ff <= of_ff;
         rpk_ff    <= opk_ff;
         rx_ff     <= ox_ff;
         ry_ff     <= oy_ff;
         rcnt_ff   <= ocnt_ff;
      end
   end

   assign rsp_valid          = ov_ff;
   assign rsp_found          = rfound_ff;
   assign rsp_peak_value     = rpk_ff;
   assign rsp_centroid_x     = rx_ff;
   assign rsp_centroid_y     = ry_ff;
   assign rsp_cluster_pixels = rcnt_ff;

   // No word is taken while the stored frame is scanned.
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pwc_pkg::ST_SCAN) |-> !req_acc)
      else $error("input accepted during scan");
   // A result only appears after the output state.
   a_out_from_state: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff) == pwc_pkg::ST_OUT)
      else $error("result without output state");
   // The load index restarts after each frame.
   a_load_restart: assert property (@(posedge clock) disable iff (reset)
      (req_acc && last_px) |=> (lidx_ff == '0))
      else $error("load index not cleared");
endmodule
`default_nettype wire

// File: design/pwc_divider.sv
`default_nettype none
// Restoring divider, one quotient bit per cycle.
module pwc_divider #(
   parameter int NUM_BITS = 48,
   parameter int DEN_BITS = 25
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic [NUM_BITS-1:0] numerator,
   input  wire logic [DEN_BITS-1:0] denominator,
   output logic                     busy,
   output logic [NUM_BITS-1:0]      quotient
);
   localparam int CntBits = $clog2(NUM_BITS + 1);

   logic [NUM_BITS-1:0] quo_ff, quo_in;
   logic [DEN_BITS:0]   rem_ff, rem_in;
   logic [DEN_BITS-1:0] den_ff;
   logic [CntBits-1:0]  cnt_ff, cnt_in;
   logic [DEN_BITS:0]   trial;

   // One shift and subtract step.
   always_comb begin
      trial  = {rem_ff[DEN_BITS-1:0], quo_ff[NUM_BITS-1]};
      quo_in = {quo_ff[NUM_BITS-2:0], 1'b0};
      rem_in = trial;
      cnt_in = cnt_ff;
      if (start) begin
         quo_in = numerator;
         rem_in = '0;
         cnt_in = CntBits'(NUM_BITS);
      end else if (cnt_ff != '0) begin
         cnt_in = cnt_ff - 1'b1;
         if (trial >= {1'b0, den_ff}) begin
            rem_in    = trial - {1'b0, den_ff};
            quo_in[0] = 1'b1;
         end
      end else begin
         quo_in = quo_ff;
         rem_in = rem_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      if (start) begin
         den_ff <= denominator;
      end
   end

   assign busy     = (cnt_ff != '0);
   assign quotient = quo_ff;
endmodule
`default_nettype wire

// File: tb/sv/pwc_checker.sv
`default_nettype none
module pwc_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_stall,
   input  wire logic [7:0]  req_pixel,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_stall,
   input  wire logic        rsp_found,
   input  wire logic [7:0]  rsp_peak_value,
   input  wire logic [16:0] rsp_centroid_x,
   input  wire logic [15:0] rsp_centroid_y,
   input  wire logic [16:0] rsp_cluster_pixels,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [pwc_pkg::CfgAddrBits-1:0] csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   input  wire logic        csr_pready,
   output int               failures,
   output int               pending,
   output int               dots_found
);
   localparam int StoreDepth = pwc_pkg::MaxWidthDefault * pwc_pkg::MaxHeightDefault;

   typedef struct packed {
      logic        found;
      logic [7:0]  peak_value;
      logic [16:0] centroid_x;
      logic [15:0] centroid_y;
      logic [16:0] cluster_pixels;
   } centroid_type;

   // Local copy of the registers and of the frame being loaded.
   logic [7:0]  threshold;
   logic [8:0]  frame_width;
   logic [7:0]  frame_height;
   logic [15:0] radius_squared;
   logic [7:0]  pixel_store [StoreDepth];
   int unsigned load_index;
   int unsigned peak_level;
   int unsigned peak_column;
   int unsigned peak_row;
   centroid_type expected_centroids[$];

   function automatic int unsigned width_in_use();
      if (frame_width == 0) return 1;
      if (frame_width > pwc_pkg::MaxWidthDefault) return pwc_pkg::MaxWidthDefault;
      return frame_width;
   endfunction

   function automatic int unsigned height_in_use();
      if (frame_height == 0) return 1;
      if (frame_height > pwc_pkg::MaxHeightDefault) return pwc_pkg::MaxHeightDefault;
      return frame_height;
   endfunction

   // Rescan the stored frame around the peak and form the weighted centroid.
   function automatic centroid_type compute_centroid(int unsigned w, int unsigned h);
      centroid_type res;
      longint unsigned weight_sum, column_sum, row_sum, dy2, dx2;
      longint signed dy, dx;
      int unsigned members, v;
      res = '0;
      res.peak_value = peak_level[7:0];
      weight_sum = 0;
      column_sum = 0;
      row_sum = 0;
      members = 0;
      if (peak_level > threshold) begin
         for (int unsigned y = 0; y < h; y++) begin
            dy = longint'(y) - longint'(peak_row);
            dy2 = dy * dy;
            if (dy2 > radius_squared) continue;
            for (int unsigned x = 0; x < w; x++) begin
               v = pixel_store[y * w + x];
               if (v <= threshold) continue;
               dx = longint'(x) - longint'(peak_column);
               dx2 = dx * dx;
               if (dx2 + dy2 > radius_squared) continue;
               weight_sum += v;
               column_sum += longint'(v) * x;
               row_sum += longint'(v) * y;
               members++;
            end
         end
         if (weight_sum != 0 && members != 0) begin
            res.found = 1'b1;
            res.centroid_x = 17'((column_sum << pwc_pkg::FractionBitsDefault) / weight_sum);
            res.centroid_y = 16'((row_sum << pwc_pkg::FractionBitsDefault) / weight_sum);
            res.cluster_pixels = 17'(members);
         end
      end
      return res;
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("ERROR: %s got %0d expected %0d", what, got, want);
      failures++;
   endtask

   always @(posedge clock) begin
      int unsigned w, h;
      centroid_type want;
      if (reset) begin
         threshold <= pwc_pkg::ThresholdReset;
         frame_width <= pwc_pkg::WidthReset;
         frame_height <= pwc_pkg::HeightReset;
         radius_squared <= pwc_pkg::RadiusReset;
         load_index = 0;
         peak_level = 0;
         peak_column = 0;
         peak_row = 0;
         expected_centroids.delete();
         failures = 0;
         dots_found = 0;
      end else begin
         // Register writes as seen on the configuration bus.
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr)
               pwc_pkg::AddrThreshold: threshold <= csr_pwdata[7:0];
               pwc_pkg::AddrWidth:     frame_width <= csr_pwdata[8:0];
               pwc_pkg::AddrHeight:    frame_height <= csr_pwdata[7:0];
               pwc_pkg::AddrRadius:    radius_squared <= csr_pwdata[15:0];
               default: ;
            endcase
         end
         // Each accepted pixel word is stored; the last one of a frame yields a result.
         if (req_valid && !req_stall) begin
            w = width_in_use();
            h = height_in_use();
            pixel_store[load_index] = req_pixel;
            if (req_pixel > peak_level) begin
               peak_level = req_pixel;
               peak_column = load_index % w;
               peak_row = load_index / w;
            end
            if (load_index + 1 < w * h) begin
               load_index++;
            end else begin
               expected_centroids.push_back(compute_centroid(w, h));
               load_index = 0;
               peak_level = 0;
               peak_column = 0;
               peak_row = 0;
            end
         end
         // Compare each accepted result word with the oldest expectation.
         if (rsp_valid && !rsp_stall) begin
            if (expected_centroids.size() == 0) begin
               report_mismatch("unexpected result, peak_value", rsp_peak_value, -1);
            end else begin
               want = expected_centroids.pop_front();
               if (want.found) dots_found++;
               if (rsp_found != want.found)
                  report_mismatch("found", rsp_found, want.found);
               if (rsp_peak_value != want.peak_value)
                  report_mismatch("peak_value", rsp_peak_value, want.peak_value);
               if (rsp_centroid_x != want.centroid_x)
                  report_mismatch("centroid_x", rsp_centroid_x, want.centroid_x);
               if (rsp_centroid_y != want.centroid_y)
                  report_mismatch("centroid_y", rsp_centroid_y, want.centroid_y);
               if (rsp_cluster_pixels != want.cluster_pixels)
                  report_mismatch("cluster_pixels", rsp_cluster_pixels, want.cluster_pixels);
            end
         end
      end
      pending = expected_centroids.size();
   end
endmodule
`default_nettype wire

// File: tb/sv/tb_top.sv
`default_nettype none
module tb_top;
   localparam int CycleLimit = 1500000;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_pixel;
   logic        rsp_valid;
   logic        rsp_stall;
   logic        rsp_found;
   logic [7:0]  rsp_peak_value;
   logic [16:0] rsp_centroid_x;
   logic [15:0] rsp_centroid_y;
   logic [16:0] rsp_cluster_pixels;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [pwc_pkg::CfgAddrBits-1:0] csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int failures, pending, dots_found;
   int cycles, words_sent, frames_sent, burst_left;

   peak_windowed_centroid DUT (.*);

   pwc_checker u_checker (
      .clock, .reset, .req_valid, .req_stall, .req_pixel,
      .rsp_valid, .rsp_stall, .rsp_found, .rsp_peak_value, .rsp_centroid_x,
      .rsp_centroid_y, .rsp_cluster_pixels, .csr_psel, .csr_penable, .csr_pwrite,
      .csr_paddr, .csr_pwdata, .csr_pready, .failures, .pending, .dots_found
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycles++;
      if (cycles > CycleLimit) begin
         $display("Timeout after %0d cycles", cycles);
         $display("Verification failed");
         $finish;
      end
   end

   // The receiver stalls in stretches of random style, with one long hold-off.
   initial begin
      int seg, style;
      rsp_stall = 1'b0;
      @(negedge reset);
      repeat (3000) @(negedge clock);
      rsp_stall <= 1'b1;
      repeat (4000) @(negedge clock);
      forever begin
         seg = $urandom_range(10, 300);
         style = $urandom_range(0, 3);
         repeat (seg) begin
            case (style)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 9) < 3);
               2: rsp_stall <= ($urandom_range(0, 9) < 8);
               default: rsp_stall <= $urandom_range(0, 1);
            endcase
            @(negedge clock);
         end
      end
   end

   task automatic write_register(input logic [pwc_pkg::CfgAddrBits-1:0] addr,
                                 input logic [31:0] data);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(negedge clock);
   endtask

   // Offer one pixel word in bursts; called and returning at a falling edge.
   task automatic send_word(input logic [7:0] px);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 1) ? $urandom_range(1, 8) : 0;
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(50, 400)
                                                : $urandom_range(1, 12);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_pixel <= px;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      words_sent++;
   endtask

   // One frame: uniform noise, a bright dot on a dim floor, a flat field or stark extremes.
   task automatic send_frame(input int w, input int h);
      int style, cx, cy, peak, d2, v;
      style = $urandom_range(0, 4);
      cx = $urandom_range(0, w - 1);
      cy = $urandom_range(0, h - 1);
      peak = $urandom_range(0, 255);
      for (int i = 0; i < w * h; i++) begin
         case (style)
            0: v = $urandom_range(0, 255);
            1, 2: begin
               d2 = (i % w - cx) * (i % w - cx) + (i / w - cy) * (i / w - cy);
               v = peak - d2 * $urandom_range(1, 12) + $urandom_range(0, 20) - 10;
               if (v < 0) v = $urandom_range(0, 40);
               if (v > 255) v = 255;
            end
            3: v = peak;
            default: v = $urandom_range(0, 1) ? 255 : 0;
         endcase
         send_word(v[7:0]);
      end
      frames_sent++;
   endtask

   // Change all registers only once the block has delivered every result.
   task automatic configure(input int thr, input int w, input int h, input int rad);
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      write_register(pwc_pkg::AddrThreshold, thr);
      write_register(pwc_pkg::AddrWidth, w);
      write_register(pwc_pkg::AddrHeight, h);
      write_register(pwc_pkg::AddrRadius, rad);
   endtask

   initial begin
      int ew, eh;
      int extremes [8][4] = '{
         '{0, 1, 1, 0}, '{255, 0, 0, 65535}, '{128, 511, 1, 144}, '{10, 1, 255, 65535},
         '{254, 320, 1, 0}, '{0, 1, 240, 65535}, '{100, 3, 2, 1}, '{1, 5, 4, 2}
      };
      reset = 1'b1;
      req_valid = 1'b0;
      req_pixel = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed single pixels at the field extremes.
      configure(0, 1, 1, 0);
      send_word(8'd0);
      send_word(8'd255);
      send_word(8'd1);
      configure(254, 1, 1, 65535);
      send_word(8'd254);
      send_word(8'd255);

      // Register extremes, saturation and zero sizes.
      foreach (extremes[i]) begin
         configure(extremes[i][0], extremes[i][1], extremes[i][2], extremes[i][3]);
         ew = extremes[i][1] == 0 ? 1 : (extremes[i][1] > 320 ? 320 : extremes[i][1]);
         eh = extremes[i][2] == 0 ? 1 : (extremes[i][2] > 240 ? 240 : extremes[i][2]);
         repeat (ew * eh > 50 ? 1 : 4) send_frame(ew, eh);
      end

      // Random settings with small frames, at most 14 by 10 pixels.
      while (words_sent < 1300) begin
         ew = $urandom_range(1, 14);
         eh = $urandom_range(1, 10);
         configure($urandom_range(0, 255), ew, eh,
                   $urandom_range(0, 3) == 0 ? 65535 : $urandom_range(0, 60));
         repeat ($urandom_range(1, 3)) send_frame(ew, eh);
      end
      req_valid <= 1'b0;

      while (pending != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      $display("Sent %0d pixel words in %0d frames; %0d frames held a dot.",
               words_sent, frames_sent, dots_found);
      if (failures == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end
endmodule
`default_nettype wire

// File: filelist.f
design/pwc_pkg.sv
design/pwc_divider.sv
design/peak_windowed_centroid.sv
tb/sv/pwc_checker.sv
tb/sv/tb_top.sv
